FILE: rtl/core/hbmt_pkg.sv
package hbmt_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int RESULT_LIMIT    = 32;
  localparam int RES_CNT_W       = $clog2(RESULT_LIMIT + 1);

  localparam logic [15:0] FAIL_AFTER_RST   = 16'd5;
  localparam logic [15:0] REMOVE_AFTER_RST = 16'd20;

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SWEEP  = 1'b1;

  localparam logic [2:0] ST_REFRESHED = 3'd0;
  localparam logic [2:0] ST_UNCHANGED = 3'd1;
  localparam logic [2:0] ST_ADDED     = 3'd2;
  localparam logic [2:0] ST_DROPPED   = 3'd3;
  localparam logic [2:0] ST_LIVE      = 3'd4;
  localparam logic [2:0] ST_NONE      = 3'd5;

  localparam logic CFG_FAIL_AFTER   = 1'b0;
  localparam logic CFG_REMOVE_AFTER = 1'b1;

  typedef struct packed {
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] beat;
    logic [31:0] tstamp;
  } entry_t;

endpackage

FILE: rtl/core/hbmt_item_if.sv
interface hbmt_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] node_id;
  logic [15:0] node_port;
  logic [31:0] beat_count;
  logic [31:0] now;

  modport source (output valid, op, node_id, node_port, beat_count, now, input ready);
  modport sink (input valid, op, node_id, node_port, beat_count, now, output ready);
endinterface

FILE: rtl/core/hbmt_result_if.sv
interface hbmt_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] out_id;
  logic [15:0] out_port;
  logic [31:0] out_beat;
  logic        last;

  modport source (output valid, status, out_id, out_port, out_beat, last, input ready);
  modport sink (input valid, status, out_id, out_port, out_beat, last, output ready);
endinterface

FILE: rtl/core/hbmt_cfg_if.sv
interface hbmt_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/hbmt_ram.sv
module hbmt_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/heartbeat_membership_table.sv
// Heartbeat membership table.
// Channels: req (item in: op, node_id, node_port, beat_count, now), rsp (results
// out: status, out_id, out_port, out_beat, last) and cfg (register writes:
// index 0 fail_after, index 1 remove_after; always ready).
// An update item gives one result: refreshed, unchanged, added or dropped.
// A sweep item deletes entries older than remove_after, compacting the table
// in order, then gives one live result per remaining entry younger than
// fail_after (at most 32, last set on the final one), or one none-live result.
// The table sits in a single RAM with registered read; a sequencer walks it
// one entry at a time (read, then age or key compare and write back).
// An update stops scanning at a match and scans every entry on a miss; a
// sweep walks every entry and also waits while the receiver stalls. The final
// result becomes valid in the same cycle that req.ready returns.
// req.ready is high only when the sequencer is idle; one item at a time.
// Results sit in an output register; a stalled receiver holds the sweep walk
// only when the next live result has to go out.
// Reset empties the table and loads fail_after = 5, remove_after = 20.
module heartbeat_membership_table #(
  parameter int TABLE_DEPTH = hbmt_pkg::TABLE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  hbmt_item_if.sink     req,
  hbmt_result_if.source rsp,
  hbmt_cfg_if.sink      cfg
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(hbmt_pkg::entry_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CHK  = 3'd2;
  localparam logic [2:0] S_MISS = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]  state;
  logic        op_r;
  logic [31:0] id_r;
  logic [15:0] port_r;
  logic [31:0] beat_r;
  logic [31:0] now_r;
  logic [15:0] fail_after;
  logic [15:0] remove_after;
  logic [CW-1:0] entry_count;
  logic [CW-1:0] rd;
  logic [CW-1:0] wr;
  logic [hbmt_pkg::RES_CNT_W-1:0] n;
  logic        pend_valid;
  hbmt_pkg::entry_t pend;
  logic [2:0]  res_status;

  hbmt_pkg::entry_t q;
  hbmt_pkg::entry_t wdata;
  logic [EW-1:0] q_raw;
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   age;
  logic          keep;
  logic          live;
  logic          match;
  logic          newer;
  logic          mid_emit;
  logic          stall;
  logic          out_free;
  logic          rsp_load;
  logic [CW-1:0] rd_inc;
  logic          has_room;

  hbmt_ram #(.W(EW), .DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd[AW-1:0]),
    .rdata (q_raw)
  );

  assign q        = q_raw;
  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_free = !rsp.valid || rsp.ready;

  always_comb begin
    age      = now_r - q.tstamp;
    keep     = age <= {16'b0, remove_after};
    live     = keep && (age < {16'b0, fail_after}) &&
               (n < hbmt_pkg::RES_CNT_W'(hbmt_pkg::RESULT_LIMIT));
    match    = (q.id == id_r) && (q.port == port_r);
    newer    = q.beat < beat_r;
    mid_emit = (state == S_CHK) && (op_r == hbmt_pkg::OP_SWEEP) && live && pend_valid;
    stall    = mid_emit && !out_free;
    rsp_load = (mid_emit && !stall) || ((state == S_FIN) && out_free);
    rd_inc   = rd + CW'(1);
    has_room = entry_count < CW'(TABLE_DEPTH);
    we       = 1'b0;
    waddr    = rd[AW-1:0];
    wdata    = q;
    unique case (state)
      S_CHK: begin
        if (op_r == hbmt_pkg::OP_SWEEP) begin
          if (keep && !stall) begin
            we    = 1'b1;
            waddr = wr[AW-1:0];
          end
        end else if (match && newer) begin
          we           = 1'b1;
          wdata.beat   = beat_r;
          wdata.tstamp = now_r;
        end
      end
      S_MISS: begin
        if (has_room) begin
          we    = 1'b1;
          waddr = entry_count[AW-1:0];
          wdata = '{id: id_r, port: port_r, beat: beat_r, tstamp: now_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      entry_count  <= '0;
      fail_after   <= hbmt_pkg::FAIL_AFTER_RST;
      remove_after <= hbmt_pkg::REMOVE_AFTER_RST;
      rsp.valid    <= 1'b0;
      pend_valid   <= 1'b0;
      n            <= '0;
      rd           <= '0;
      wr           <= '0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          hbmt_pkg::CFG_FAIL_AFTER:   fail_after   <= cfg.data;
          hbmt_pkg::CFG_REMOVE_AFTER: remove_after <= cfg.data;
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready && !rsp_load) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_r       <= req.op;
            id_r       <= req.node_id;
            port_r     <= req.node_port;
            beat_r     <= req.beat_count;
            now_r      <= req.now;
            rd         <= '0;
            wr         <= '0;
            n          <= '0;
            pend_valid <= 1'b0;
            if (entry_count != '0) begin
              state <= S_RD;
            end else if (req.op == hbmt_pkg::OP_SWEEP) begin
              state <= S_FIN;
            end else begin
              state <= S_MISS;
            end
          end
        end
        S_RD: begin
          state <= S_CHK;
        end
        S_CHK: begin
          if (op_r == hbmt_pkg::OP_SWEEP) begin
            if (!stall) begin
              if (keep) begin
                wr <= wr + CW'(1);
              end
              if (live) begin
                if (pend_valid) begin
                  rsp.valid    <= 1'b1;
                  rsp.status   <= hbmt_pkg::ST_LIVE;
                  rsp.out_id   <= pend.id;
                  rsp.out_port <= pend.port;
                  rsp.out_beat <= pend.beat;
                  rsp.last     <= 1'b0;
                end
                pend       <= q;
                pend_valid <= 1'b1;
                n          <= n + hbmt_pkg::RES_CNT_W'(1);
              end
              rd <= rd_inc;
              if (rd_inc < entry_count) begin
                state <= S_RD;
              end else begin
                state       <= S_FIN;
                entry_count <= keep ? wr + CW'(1) : wr;
              end
            end
          end else if (match) begin
            res_status <= newer ? hbmt_pkg::ST_REFRESHED : hbmt_pkg::ST_UNCHANGED;
            state      <= S_FIN;
          end else begin
            rd    <= rd_inc;
            state <= (rd_inc < entry_count) ? S_RD : S_MISS;
          end
        end
        S_MISS: begin
          if (has_room) begin
            entry_count <= entry_count + CW'(1);
            res_status  <= hbmt_pkg::ST_ADDED;
          end else begin
            res_status  <= hbmt_pkg::ST_DROPPED;
          end
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            rsp.valid <= 1'b1;
            rsp.last  <= 1'b1;
            if (op_r == hbmt_pkg::OP_SWEEP && pend_valid) begin
              rsp.status   <= hbmt_pkg::ST_LIVE;
              rsp.out_id   <= pend.id;
              rsp.out_port <= pend.port;
              rsp.out_beat <= pend.beat;
            end else begin
              rsp.status   <= (op_r == hbmt_pkg::OP_SWEEP) ? hbmt_pkg::ST_NONE : res_status;
              rsp.out_id   <= '0;
              rsp.out_port <= '0;
              rsp.out_beat <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_result_limit: assert property (@(posedge clk) disable iff (rst)
    n <= hbmt_pkg::RES_CNT_W'(hbmt_pkg::RESULT_LIMIT))
    else $error("too many live results in one sweep");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("ready while an item is in progress");

  a_compact_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK && op_r == hbmt_pkg::OP_SWEEP) |-> (wr <= rd))
    else $error("compaction write index passed read index");

  a_no_emit_over_full: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> $stable(rsp.status) && $stable(rsp.out_id))
    else $error("result changed while stalled");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
module tb;

  localparam int DEPTH = hbmt_pkg::TABLE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int POOL_SIZE = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 30;

  typedef struct packed {
    logic        op;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] beat;
    logic [31:0] now;
  } beat_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] beat;
    logic        last;
  } report_t;

  typedef struct packed {
    beat_item_t item;
    logic       typed;
    logic [2:0] status;
  } dir_row_t;

  logic clk;
  logic rst;

  hbmt_item_if   req_if ();
  hbmt_result_if rsp_if ();
  hbmt_cfg_if    cfg_if ();

  heartbeat_membership_table uut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // typed status only where it is obvious; the rest comes from the table tracker
  dir_row_t dir_rows [18] = '{
    '{'{hbmt_pkg::OP_SWEEP,  32'h0,        16'h0,    32'h0,        32'h0       },
      1'b1, hbmt_pkg::ST_NONE},
    '{'{hbmt_pkg::OP_UPDATE, 32'h0,        16'h0,    32'h0,        32'h0       },
      1'b1, hbmt_pkg::ST_ADDED},
    '{'{hbmt_pkg::OP_UPDATE, 32'h0,        16'h0,    32'h0,        32'h1       },
      1'b1, hbmt_pkg::ST_UNCHANGED},
    '{'{hbmt_pkg::OP_UPDATE, 32'h0,        16'h0,    32'h1,        32'h2       },
      1'b1, hbmt_pkg::ST_REFRESHED},
    '{'{hbmt_pkg::OP_UPDATE, 32'h0,        16'h0,    32'h0,        32'h2       },
      1'b1, hbmt_pkg::ST_UNCHANGED},
    '{'{hbmt_pkg::OP_UPDATE, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
      1'b1, hbmt_pkg::ST_ADDED},
    '{'{hbmt_pkg::OP_UPDATE, 32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'h3       },
      1'b1, hbmt_pkg::ST_UNCHANGED},
    '{'{hbmt_pkg::OP_UPDATE, 32'h0,        16'hFFFF, 32'h5,        32'h3       },
      1'b1, hbmt_pkg::ST_ADDED},
    '{'{hbmt_pkg::OP_UPDATE, 32'hFFFFFFFF, 16'h0,    32'h5,        32'h3       },
      1'b1, hbmt_pkg::ST_ADDED},
    '{'{hbmt_pkg::OP_SWEEP,  32'hFFFFFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'h4       },
      1'b0, hbmt_pkg::ST_NONE},
    '{'{hbmt_pkg::OP_SWEEP,  32'h0,        16'h0,    32'h0,        32'd22      },
      1'b0, hbmt_pkg::ST_NONE},
    '{'{hbmt_pkg::OP_SWEEP,  32'h0,        16'h0,    32'h0,        32'd23      },
      1'b0, hbmt_pkg::ST_NONE},
    '{'{hbmt_pkg::OP_UPDATE, 32'h0,        16'hFFFF, 32'h6,        32'd23      },
      1'b0, hbmt_pkg::ST_NONE},
    '{'{hbmt_pkg::OP_SWEEP,  32'h0,        16'h0,    32'h0,        32'd24      },
      1'b0, hbmt_pkg::ST_NONE},
    '{'{hbmt_pkg::OP_UPDATE, 32'h12345678, 16'hABCD, 32'h80000000, 32'd24      },
      1'b0, hbmt_pkg::ST_NONE},
    '{'{hbmt_pkg::OP_SWEEP,  32'h0,        16'h0,    32'h0,        32'd24      },
      1'b0, hbmt_pkg::ST_NONE},
    '{'{hbmt_pkg::OP_SWEEP,  32'h0,        16'h0,    32'h0,        32'h80000000},
      1'b0, hbmt_pkg::ST_NONE},
    '{'{hbmt_pkg::OP_SWEEP,  32'h0,        16'h0,    32'h0,        32'h80000000},
      1'b1, hbmt_pkg::ST_NONE}
  };

  logic [15:0] fail_plan   [PHASES] = '{16'd3, 16'd0, 16'hFFFF, 16'd12, 16'd5, 16'd0};
  logic [15:0] remove_plan [PHASES] = '{16'd10, 16'd0, 16'hFFFF, 16'd6, 16'd20, 16'd0};

  // shadow of the membership table
  logic [31:0] tbl_id   [DEPTH];
  logic [15:0] tbl_port [DEPTH];
  logic [31:0] tbl_beat [DEPTH];
  logic [31:0] tbl_time [DEPTH];
  int          tbl_count;
  logic [15:0] live_age;
  logic [15:0] purge_age;

  report_t pending_reports [$];
  report_t due_report;
  report_t seen_report;

  logic [31:0] pool_id   [POOL_SIZE];
  logic [15:0] pool_port [POOL_SIZE];
  logic [31:0] pool_beat [POOL_SIZE];

  int mismatch_count = 0;
  int cycle_count = 0;
  int tx_idle_pct = 33;
  int rx_idle_pct = 45;
  int hold_asks = 0;
  int hold_done = 0;
  int hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("heartbeat_membership_table test failed");
      $finish;
    end
  end

  function automatic void add_report(input report_t r);
    pending_reports.insert(pending_reports.size(), r);
  endfunction

  // returns how many results the item adds to the queue
  function automatic int track_membership(input beat_item_t it);
    int i;
    int hit;
    int wr;
    int n;
    int cnt;
    logic [31:0] age;
    report_t r;
    r = '0;
    r.last = 1'b1;
    cnt = 1;
    if (it.op == hbmt_pkg::OP_UPDATE) begin
      hit = -1;
      for (i = 0; i < tbl_count; i++)
        if (hit < 0 && tbl_id[i] == it.id && tbl_port[i] == it.port) hit = i;
      if (hit >= 0) begin
        if (tbl_beat[hit] < it.beat) begin
          tbl_beat[hit] = it.beat;
          tbl_time[hit] = it.now;
          r.status = hbmt_pkg::ST_REFRESHED;
        end else begin
          r.status = hbmt_pkg::ST_UNCHANGED;
        end
      end else if (tbl_count >= DEPTH) begin
        r.status = hbmt_pkg::ST_DROPPED;
      end else begin
        tbl_id[tbl_count]   = it.id;
        tbl_port[tbl_count] = it.port;
        tbl_beat[tbl_count] = it.beat;
        tbl_time[tbl_count] = it.now;
        tbl_count++;
        r.status = hbmt_pkg::ST_ADDED;
      end
      add_report(r);
    end else begin
      wr = 0;
      n = 0;
      for (i = 0; i < tbl_count; i++) begin
        age = it.now - tbl_time[i];
        if (age <= {16'h0, purge_age}) begin
          tbl_id[wr]   = tbl_id[i];
          tbl_port[wr] = tbl_port[i];
          tbl_beat[wr] = tbl_beat[i];
          tbl_time[wr] = tbl_time[i];
          if (age < {16'h0, live_age} && n < hbmt_pkg::RESULT_LIMIT) begin
            r.status = hbmt_pkg::ST_LIVE;
            r.id     = tbl_id[wr];
            r.port   = tbl_port[wr];
            r.beat   = tbl_beat[wr];
            r.last   = 1'b0;
            add_report(r);
            n++;
          end
          wr++;
        end
      end
      tbl_count = wr;
      if (n == 0) begin
        r = '0;
        r.status = hbmt_pkg::ST_NONE;
        r.last = 1'b1;
        add_report(r);
      end else begin
        r = pending_reports.pop_back();
        r.last = 1'b1;
        add_report(r);
        cnt = n;
      end
    end
    return cnt;
  endfunction

  always @(negedge clk) begin
    if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      seen_report = '{rsp_if.status, rsp_if.out_id, rsp_if.out_port, rsp_if.out_beat,
                      rsp_if.last};
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected item: status %0d id %h port %h beat %h last %b", $time,
                 seen_report.status, seen_report.id, seen_report.port, seen_report.beat,
                 seen_report.last);
      end else begin
        due_report = pending_reports.pop_front();
        if (seen_report.status !== due_report.status || seen_report.id !== due_report.id ||
            seen_report.port !== due_report.port || seen_report.beat !== due_report.beat ||
            seen_report.last !== due_report.last) begin
          mismatch_count++;
          $display("%0t: expected status %0d id %h port %h beat %h last %b", $time,
                   due_report.status, due_report.id, due_report.port, due_report.beat,
                   due_report.last);
          $display("%0t: actual   status %0d id %h port %h beat %h last %b", $time,
                   seen_report.status, seen_report.id, seen_report.port, seen_report.beat,
                   seen_report.last);
        end
      end
    end
  end

  task automatic send_item(input beat_item_t it, input logic typed,
                           input logic [2:0] typed_status);
    int added;
    report_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid      = 1'b1;
    req_if.op         = it.op;
    req_if.node_id    = it.id;
    req_if.node_port  = it.port;
    req_if.beat_count = it.beat;
    req_if.now        = it.now;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    added = track_membership(it);
    if (typed) begin
      repeat (added) void'(pending_reports.pop_back());
      r = '0;
      r.status = typed_status;
      r.last = 1'b1;
      add_report(r);
    end
    @(negedge clk);
  endtask

  task automatic set_limit(input logic idx, input logic [15:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    if (idx == hbmt_pkg::CFG_FAIL_AFTER) live_age = val;
    else purge_age = val;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // block goes idle: all results in, then room for a sweep walk to finish compacting
  task automatic settle();
    req_if.valid = 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    beat_item_t it;
    int phase;
    int k;
    int j;
    int pick;
    logic [31:0] clock_now;
    logic [15:0] fail_val;
    logic [15:0] remove_val;

    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.op = hbmt_pkg::OP_UPDATE;
    req_if.node_id = '0;
    req_if.node_port = '0;
    req_if.beat_count = '0;
    req_if.now = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = hbmt_pkg::CFG_FAIL_AFTER;
    cfg_if.data = '0;
    rsp_if.ready = 1'b0;
    live_age = hbmt_pkg::FAIL_AFTER_RST;
    purge_age = hbmt_pkg::REMOVE_AFTER_RST;
    tbl_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].status);
    settle();

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase == 2) begin
        tx_idle_pct = 45;
        rx_idle_pct = 33;
      end else if (phase == 4) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      fail_val = fail_plan[phase];
      remove_val = remove_plan[phase];
      if (phase == PHASES - 1) begin
        fail_val = 16'($urandom_range(40));
        remove_val = 16'($urandom_range(60));
      end
      set_limit(hbmt_pkg::CFG_FAIL_AFTER, fail_val);
      set_limit(hbmt_pkg::CFG_REMOVE_AFTER, remove_val);

      for (k = 0; k < POOL_SIZE; k++) begin
        pool_id[k] = $urandom;
        pool_port[k] = 16'($urandom_range(65535));
        pool_beat[k] = $urandom;
      end
      clock_now = $urandom;

      // fill past capacity while the receiver holds off
      if (phase == 2) begin
        hold_asks++;
        for (k = 0; k < DEPTH + 4; k++) begin
          it = '{hbmt_pkg::OP_UPDATE, pool_id[k], pool_port[k], pool_beat[k], clock_now};
          send_item(it, 1'b0, hbmt_pkg::ST_NONE);
        end
      end

      for (k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(99);
        if ($urandom_range(39) == 0) clock_now = clock_now + $urandom;
        else clock_now = clock_now + $urandom_range(3);
        it.op = hbmt_pkg::OP_UPDATE;
        it.id = $urandom;
        it.port = 16'($urandom_range(65535));
        it.beat = $urandom;
        it.now = clock_now;
        if (pick < 16) begin
          it.op = hbmt_pkg::OP_SWEEP;
        end else if (pick < 90) begin
          j = (pick < 35) ? $urandom_range(3) : $urandom_range(POOL_SIZE - 1);
          it.id = pool_id[j];
          it.port = pool_port[j];
          if ($urandom_range(7) != 0) it.beat = pool_beat[j] + $urandom_range(3) - 1;
          if (it.beat > pool_beat[j]) pool_beat[j] = it.beat;
        end
        send_item(it, 1'b0, hbmt_pkg::ST_NONE);
      end
      settle();
    end

    if (mismatch_count == 0) $display("heartbeat_membership_table test passed");
    else $display("heartbeat_membership_table test failed");
    $finish;
  end

endmodule
